// ----- src/http_header_name_matcher_macros.svh -----
// Assertion macros used by the header name matcher top level.
`ifndef HTTP_HEADER_NAME_MATCHER_MACROS_SVH
`define HTTP_HEADER_NAME_MATCHER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset.
`define HHNM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset.
`define HHNM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HHNM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define HHNM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/hhnm_pkg.sv -----
// Shared types, constants and the header name dictionary for the name matcher.
package hhnm_pkg;

    localparam int NUM_NAMES    = 62;
    localparam int MAX_NAME_LEN = 27;
    localparam int POS_W        = 5;
    localparam int IDX_W        = 6;
    localparam int DICT_CHARS   = 32;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // One input beat: a byte of the name and the end-of-name marker.
    typedef struct packed {
        logic [7:0] name_byte;
        logic       last;
    } name_beat_t;

    // One result beat.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] token_index;
    } result_t;

    // Result handed from the match core to the output register.
    typedef struct packed {
        logic    emit;
        result_t result;
    } core_out_t;

    // Dictionary text, right-aligned: the last character sits in the low byte.
    localparam logic [8*DICT_CHARS-1:0] DICT_TEXT [NUM_NAMES] = '{
        ":authority", ":method", ":path", ":scheme",
        ":status", "accept", "accept-charset",
        "accept-encoding", "accept-language", "accept-ranges",
        "access-control-allow-origin", "age", "allow",
        "authorization", "cache-control", "cache-digest",
        "connection", "content-disposition",
        "content-encoding", "content-language",
        "content-length", "content-location",
        "content-range", "content-type", "cookie",
        "date", "etag", "expect", "expires", "from",
        "host", "http2-settings", "if-match",
        "if-modified-since", "if-none-match", "if-range",
        "if-unmodified-since", "keep-alive", "last-modified",
        "link", "location", "max-forwards",
        "proxy-authenticate", "proxy-authorization", "range",
        "referer", "refresh", "retry-after", "server",
        "set-cookie", "strict-transport-security", "te",
        "transfer-encoding", "upgrade", "user-agent",
        "vary", "via", "www-authenticate",
        "x-compress-hint", "x-forwarded-for", "x-reproxy-url",
        "x-traffic"
    };

    // Length of each dictionary entry in bytes.
    localparam logic [POS_W-1:0] DICT_LEN [NUM_NAMES] = '{
        5'd10, 5'd7, 5'd5, 5'd7,
        5'd7, 5'd6, 5'd14,
        5'd15, 5'd15, 5'd13,
        5'd27, 5'd3, 5'd5,
        5'd13, 5'd13, 5'd12,
        5'd10, 5'd19,
        5'd16, 5'd16,
        5'd14, 5'd16,
        5'd13, 5'd12, 5'd6,
        5'd4, 5'd4, 5'd6, 5'd7, 5'd4,
        5'd4, 5'd14, 5'd8,
        5'd17, 5'd13, 5'd8,
        5'd19, 5'd10, 5'd13,
        5'd4, 5'd8, 5'd12,
        5'd18, 5'd19, 5'd5,
        5'd7, 5'd7, 5'd11, 5'd6,
        5'd10, 5'd25, 5'd2,
        5'd17, 5'd7, 5'd10,
        5'd4, 5'd3, 5'd16,
        5'd15, 5'd15, 5'd13,
        5'd9
    };

endpackage

// ----- src/hhnm_in_reg.sv -----
// Input register stage: captures one name beat and holds it until the core consumes it.
module hhnm_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  hhnm_pkg::name_beat_t byte_data,
    input  logic                consume,
    output logic                beat_valid,
    output hhnm_pkg::name_beat_t beat
);
    import hhnm_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    name_beat_t beat_reg;
    logic       load;

    // Stall the sender while a held beat cannot move on
    assign byte_stall = valid_reg && !consume;
    assign load       = byte_valid && !byte_stall;

    // Keep the stage full while new beats arrive
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on every accepted beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= byte_data;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ----- src/hhnm_match_core.sv -----
// Match core: candidate mask and byte position, updated once per consumed beat.
module hhnm_match_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 consume,
    input  hhnm_pkg::name_beat_t beat,
    output hhnm_pkg::core_out_t  core_out
);
    import hhnm_pkg::*;

    logic [NUM_NAMES-1:0] cand_mask_reg;
    logic [NUM_NAMES-1:0] cand_mask_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [NUM_NAMES-1:0] match_vec;
    logic [NUM_NAMES-1:0] new_mask;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;

    // Compare the byte against each surviving entry at the current position
    always_comb
    begin
        logic [POS_W-1:0] off;
        match_vec = '0;
        for (int i = 0; i < NUM_NAMES; i++)
        begin
            off = DICT_LEN[i] - POS_W'(1) - pos_reg;
            match_vec[i] = cand_mask_reg[i] && (pos_reg < DICT_LEN[i]) &&
                           (DICT_TEXT[i][{off, 3'b000} +: 8] == beat.name_byte);
        end
        new_mask = (pos_reg < POS_W'(MAX_NAME_LEN)) ? match_vec : '0;
    end

    // Pick the entry whose length equals the bytes seen; entries are distinct,
    // so at most one can hit and OR-ing the indexes is enough
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < NUM_NAMES; i++)
        begin
            if (new_mask[i] &&
                ({1'b0, DICT_LEN[i]} == ({1'b0, pos_reg} + (POS_W+1)'(1))) &&
                (DICT_LEN[i] <= POS_W'(MAX_NAME_LEN)))
            begin
                hit     = 1'b1;
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    // Advance the state, or rewind it at the end of a name
    always_comb
    begin
        cand_mask_next = cand_mask_reg;
        pos_next       = pos_reg;
        if (consume)
        begin
            if (beat.last)
            begin
                cand_mask_next = '1;
                pos_next       = '0;
            end
            else
            begin
                cand_mask_next = new_mask;
                pos_next       = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_mask_reg <= '1;
            pos_reg       <= '0;
        end
        else
        begin
            cand_mask_reg <= cand_mask_next;
            pos_reg       <= pos_next;
        end
    end

    assign core_out.emit               = consume && beat.last;
    assign core_out.result.found       = hit;
    assign core_out.result.token_index = hit_idx;

endmodule

// ----- src/hhnm_out_reg.sv -----
// Output register: holds one result beat until the receiver takes it.
module hhnm_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  hhnm_pkg::core_out_t core_out,
    output logic                out_free,
    output logic                result_valid,
    input  logic                result_stall,
    output hhnm_pkg::result_t   result_data
);
    import hhnm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can take a new beat when empty or being drained
    assign out_free = !valid_reg || !result_stall;

    // Hold the beat while stalled, drop it once taken
    always_comb
    begin
        if (core_out.emit)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_out.emit)
        begin
            data_reg <= core_out.result;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule

// ----- src/http_header_name_matcher.sv -----
// Top level of the HTTP header name matcher.
// Takes a header field name one byte per beat (last marks the final byte) and, on the
// final byte, delivers one result beat: found, and the index 0..61 of the dictionary
// entry that equals the whole name case-sensitively (index 0 when not found). Names
// longer than 27 bytes are never found. The block accepts one byte every cycle while
// the result side is not stalled; a byte passes an input register, then compare logic
// against all 62 entries updates the candidate mask and loads the result register.
// No clearing pass after reset.
module http_header_name_matcher (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  hhnm_pkg::name_beat_t byte_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output hhnm_pkg::result_t    result_data
);
    import hhnm_pkg::*;
    `include "http_header_name_matcher_macros.svh"

    logic       beat_valid;
    name_beat_t beat;
    logic       out_free;
    logic       consume;
    core_out_t  core_out;

    // Move the held beat into the core when the result side has room
    assign consume = beat_valid && out_free;

    hhnm_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .consume    (consume),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    hhnm_match_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .consume  (consume),
        .beat     (beat),
        .core_out (core_out)
    );

    hhnm_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .core_out     (core_out),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    `HHNM_ASSERT_NOW(a_stall_needs_beat, clk, rst_n, byte_stall, beat_valid, "stall without a held beat")
    `HHNM_ASSERT_NEXT(a_last_gives_result, clk, rst_n, consume && beat.last, result_valid, "final byte produced no result")
    `HHNM_ASSERT_NOW(a_miss_index_zero, clk, rst_n, result_valid && !result_data.found, result_data.token_index == '0, "miss with nonzero index")
    `HHNM_ASSERT_NEXT(a_rewind_after_last, clk, rst_n, consume && beat.last, (u_core.pos_reg == '0), "position not rewound")
    `HHNM_ASSERT_NOW(a_emit_has_room, clk, rst_n, core_out.emit, out_free, "result emitted into a full register")

endmodule
